// ----- hw/rtl/serial_door_sequencer_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the door sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef SERIAL_DOOR_SEQUENCER_DEFINES_SVH
`define SERIAL_DOOR_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sds_pkg.sv -----
// ---------------------------------------------------------------------------
// sds_pkg
// Types, codes and helper functions of the serial door sequencer.
// ---------------------------------------------------------------------------
package sds_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_OPENING = 2'd1,
    PH_HOLD    = 2'd2,
    PH_CLOSING = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    RC_NONE     = 3'd0,
    RC_ACK_DONE = 3'd1,
    RC_PONG     = 3'd2,
    RC_ERR_BUSY = 3'd3,
    RC_ERR_CMD  = 3'd4
  } reply_t;

  // Outcome of one received byte as seen by the line assembler.
  typedef enum logic [1:0] {
    LC_NONE = 2'd0,
    LC_OPEN = 2'd1,
    LC_PING = 2'd2,
    LC_BAD  = 2'd3
  } line_cmd_t;

  typedef enum logic [1:0] {
    REG_MOVE_TIME  = 2'd0,
    REG_HOLD_OPEN  = 2'd1,
    REG_OPEN_ANGLE = 2'd2,
    REG_CLOSE_ANGLE = 2'd3
  } reg_idx_t;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [31:0] WORD_OPEN = {8'h4F, 8'h50, 8'h45, 8'h4E};  // "OPEN"
  localparam logic [31:0] WORD_PING = {8'h50, 8'h49, 8'h4E, 8'h47};  // "PING"
  localparam logic [31:0] WORD_CMD  = {8'h43, 8'h4D, 8'h44, 8'h3A};  // "CMD:"

  localparam int PREFIX_DEPTH = 8;

  localparam logic [7:0]  ANGLE_CEIL    = 8'd180;
  localparam logic [11:0] COMPARE_BASE  = 12'd500;
  // 2000/180 scaled by 2^18, rounded up; exact for every angle up to 180.
  localparam logic [21:0] COMPARE_RECIP = 22'd2912712;
  localparam int          COMPARE_SHIFT = 18;

  // Servo compare value in microseconds for an angle in degrees.
  function automatic logic [11:0] angle_to_compare(input logic [7:0] angle);
    logic [7:0]  a_sat;
    logic [29:0] prod;
    a_sat = (angle > ANGLE_CEIL) ? ANGLE_CEIL : angle;
    prod  = 30'(a_sat) * 30'(COMPARE_RECIP);
    return COMPARE_BASE + 12'(prod >> COMPARE_SHIFT);
  endfunction

endpackage

// ----- hw/rtl/sds_if.sv -----
// ---------------------------------------------------------------------------
// sds_in_if / sds_out_if
// Valid/ready channels for request items and result items.
// ---------------------------------------------------------------------------
interface sds_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_data;

  modport source (output valid, output req_type, output rx_data, input ready);
  modport sink   (input valid, input req_type, input rx_data, output ready);
endinterface

interface sds_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reply_code;
  logic [11:0] servo_compare;
  logic [1:0]  door_phase;

  modport source (output valid, output reply_code, output servo_compare,
                  output door_phase, input ready);
  modport sink   (input valid, input reply_code, input servo_compare,
                  input door_phase, output ready);
endinterface

// ----- hw/rtl/sds_line.sv -----
// ---------------------------------------------------------------------------
// sds_line
// Command line assembler: collects bytes, keeps the first eight, and
// decodes the line when LF arrives.
// ---------------------------------------------------------------------------
`include "serial_door_sequencer_defines.svh"

module sds_line
  import sds_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  logic [7:0] rx_data,
  output line_cmd_t  cmd
);

  localparam int              LEN_W   = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);
  localparam logic [LEN_W-1:0] LEN_4   = LEN_W'(4);
  localparam logic [LEN_W-1:0] LEN_8   = LEN_W'(8);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       prefix_r [PREFIX_DEPTH];
  logic [31:0]      head_word, tail_word;
  logic             in_prefix;
  logic             is_open, is_ping;

  assign head_word = {prefix_r[0], prefix_r[1], prefix_r[2], prefix_r[3]};
  assign tail_word = {prefix_r[4], prefix_r[5], prefix_r[6], prefix_r[7]};
  assign in_prefix = (len_r >> 3) == '0;

  // A line matches only at its exact length, bare or behind "CMD:".
  assign is_open = ((len_r == LEN_4) && (head_word == WORD_OPEN)) ||
                   ((len_r == LEN_8) && (head_word == WORD_CMD) && (tail_word == WORD_OPEN));
  assign is_ping = ((len_r == LEN_4) && (head_word == WORD_PING)) ||
                   ((len_r == LEN_8) && (head_word == WORD_CMD) && (tail_word == WORD_PING));

  always_comb begin
    len_nxt = len_r;
    cmd     = LC_NONE;
    if (byte_vld) begin
      priority if (rx_data == CHAR_CR) begin
        len_nxt = len_r;
      end else if (rx_data == CHAR_LF) begin
        len_nxt = '0;
        if (len_r != '0) begin
          priority if (is_open) cmd = LC_OPEN;
          else if (is_ping)     cmd = LC_PING;
          else                  cmd = LC_BAD;
        end
      end else if (len_r < LEN_MAX) begin
        len_nxt = len_r + LEN_W'(1);
      end else begin
        // Overlong line: drop it and report a bad command.
        len_nxt = '0;
        cmd     = LC_BAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_vld && (rx_data != CHAR_CR) && (rx_data != CHAR_LF) &&
        (len_r < LEN_MAX) && in_prefix) begin
      prefix_r[len_r[2:0]] <= rx_data;
    end
  end

  `SDS_ASSERT_NOW(a_len_bound, clk, rst_n, 1'b1, len_r <= LEN_MAX, "line length over capacity")
  `SDS_ASSERT_NEXT(a_cr_keeps, clk, rst_n, byte_vld && (rx_data == CHAR_CR), len_r == $past(len_r), "CR changed line length")
  `SDS_ASSERT_NEXT(a_lf_clears, clk, rst_n, byte_vld && (rx_data == CHAR_LF), len_r == '0, "LF did not empty the line")

endmodule

// ----- hw/rtl/serial_door_sequencer.sv -----
// ---------------------------------------------------------------------------
// serial_door_sequencer
// Serial-commanded door servo sequencer with an APB register port.
// ---------------------------------------------------------------------------
// Each request is either a received serial byte or a one millisecond tick,
// and each one yields exactly one result carrying a reply code, the servo
// compare value and the door phase after that request. A request is taken
// in every cycle in which the result register is empty or being drained, and
// its result is valid in the next cycle; throughput is one request per clock,
// set by the single register stage between the request and result channels.
// No clearing pass runs after reset. Registers live at byte addresses 0
// (move time), 4 (hold time), 8 (open angle) and 12 (close angle).
`include "serial_door_sequencer_defines.svh"

module serial_door_sequencer
  import sds_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  sds_in_if.sink       in_ch,
  sds_out_if.source    out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0] move_time_r, hold_open_r;
  logic [7:0]  open_angle_r, close_angle_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  phase_t      phase_r, phase_nxt;
  logic [15:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [11:0] servo_r, servo_nxt;
  logic [11:0] open_cmp, close_cmp;
  reply_t      reply_nxt;
  line_cmd_t   line_cmd;

  logic        in_acc, is_tick;
  logic        out_valid_r;
  reply_t      reply_r;
  logic [11:0] servo_out_r;
  phase_t      phase_out_r;

  // Register port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_time_r   <= 16'd500;
      hold_open_r   <= 16'd3000;
      open_angle_r  <= 8'd90;
      close_angle_r <= 8'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MOVE_TIME:   move_time_r   <= pwdata[15:0];
        REG_HOLD_OPEN:   hold_open_r   <= pwdata[15:0];
        REG_OPEN_ANGLE:  open_angle_r  <= pwdata[7:0];
        REG_CLOSE_ANGLE: close_angle_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MOVE_TIME:   prdata = {16'd0, move_time_r};
      REG_HOLD_OPEN:   prdata = {16'd0, hold_open_r};
      REG_OPEN_ANGLE:  prdata = {24'd0, open_angle_r};
      REG_CLOSE_ANGLE: prdata = {24'd0, close_angle_r};
      default:         prdata = '0;
    endcase
  end

  // Request channel.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_tick     = in_ch.req_type;

  sds_line #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_acc && !is_tick),
    .rx_data  (in_ch.rx_data),
    .cmd      (line_cmd)
  );

  assign open_cmp    = angle_to_compare(open_angle_r);
  assign close_cmp   = angle_to_compare(close_angle_r);
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;

  // Door sequencer: next state.
  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    servo_nxt   = servo_r;
    if (in_acc) begin
      if (is_tick) begin
        unique case (phase_r)
          PH_IDLE: ;
          PH_OPENING: begin
            if (elapsed_inc >= move_time_r) begin
              phase_nxt   = PH_HOLD;
              elapsed_nxt = '0;
            end else begin
              elapsed_nxt = elapsed_inc;
            end
          end
          PH_HOLD: begin
            if (elapsed_inc >= hold_open_r) begin
              phase_nxt   = PH_CLOSING;
              elapsed_nxt = '0;
              servo_nxt   = close_cmp;
            end else begin
              elapsed_nxt = elapsed_inc;
            end
          end
          PH_CLOSING: begin
            if (elapsed_inc >= move_time_r) begin
              phase_nxt   = PH_IDLE;
              elapsed_nxt = '0;
              servo_nxt   = '0;
            end else begin
              elapsed_nxt = elapsed_inc;
            end
          end
          default: ;
        endcase
      end else if ((line_cmd == LC_OPEN) && (phase_r == PH_IDLE)) begin
        phase_nxt   = PH_OPENING;
        elapsed_nxt = '0;
        servo_nxt   = open_cmp;
      end
    end
  end

  // Door sequencer: reply code.
  always_comb begin
    reply_nxt = RC_NONE;
    if (is_tick) begin
      if ((phase_r == PH_OPENING) && (elapsed_inc >= move_time_r)) begin
        reply_nxt = RC_ACK_DONE;
      end
    end else begin
      unique case (line_cmd)
        LC_NONE: reply_nxt = RC_NONE;
        LC_OPEN: reply_nxt = (phase_r == PH_IDLE) ? RC_NONE : RC_ERR_BUSY;
        LC_PING: reply_nxt = RC_PONG;
        LC_BAD:  reply_nxt = RC_ERR_CMD;
        default: reply_nxt = RC_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      servo_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      servo_r   <= servo_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      reply_r     <= reply_nxt;
      servo_out_r <= servo_nxt;
      phase_out_r <= phase_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.reply_code    = reply_r;
  assign out_ch.servo_compare = servo_out_r;
  assign out_ch.door_phase    = phase_out_r;

  `SDS_ASSERT_NOW(a_servo_idle, clk, rst_n, 1'b1, (phase_r == PH_IDLE) == (servo_r == '0), "servo level disagrees with idle phase")
  `SDS_ASSERT_NOW(a_idle_count, clk, rst_n, phase_r == PH_IDLE, elapsed_r == '0, "tick count running while idle")
  `SDS_ASSERT_NEXT(a_ack_hold, clk, rst_n, in_acc && (reply_nxt == RC_ACK_DONE), phase_r == PH_HOLD, "ACK:DONE without entering hold")

endmodule
